// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file lcbf_checker.sv.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHK_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define CHK_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== hw/rtl/lcbf_pkg.sv =====
// Shared types, codes and constants for the LED color buffer with fade.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
package lcbf_pkg;

    localparam int LED_COUNT_DEF = 60;
    localparam int IDX_W         = 10;
    localparam int COLOR_W       = 24;
    localparam int CHAN_W        = 8;
    localparam int OP_W          = 2;
    localparam int S_TDATA_W     = 48;

    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_FADE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FADE,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic               status;
        logic [COLOR_W-1:0] color;
    } res_t;

    // Subtract amount from each 8-bit channel, floor at zero.
    function automatic logic [COLOR_W-1:0] fade_color(
        input logic [COLOR_W-1:0] col,
        input logic [CHAN_W-1:0]  amount
    );
        logic [COLOR_W-1:0] result;
        logic [CHAN_W-1:0]  chan;
        result = '0;
        for (int i = 0; i < COLOR_W / CHAN_W; i++) begin
            chan = col[i*CHAN_W +: CHAN_W];
            result[i*CHAN_W +: CHAN_W] = (chan > amount) ? (chan - amount) : '0;
        end
        return result;
    endfunction

endpackage

// ===== hw/rtl/lcbf_mem.sv =====
// Color store: one write port and one registered read port.
// Depends on lcbf_pkg for the color width.
module lcbf_mem #(
    parameter int LED_COUNT = lcbf_pkg::LED_COUNT_DEF,
    parameter int ADDR_W    = 6
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [lcbf_pkg::COLOR_W-1:0] wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [lcbf_pkg::COLOR_W-1:0] rdata
);
    import lcbf_pkg::*;

    logic [COLOR_W-1:0] mem [LED_COUNT];
    logic [COLOR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lcbf_ctrl.sv =====
// Request sequencer: clear pass, set, read and the read-modify-write fade sweep.
// Depends on lcbf_pkg; drives the ports of lcbf_mem.
module lcbf_ctrl #(
    parameter int LED_COUNT = lcbf_pkg::LED_COUNT_DEF,
    parameter int ADDR_W    = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lcbf_pkg::OP_W-1:0]     op,
    input  logic [lcbf_pkg::IDX_W-1:0]    led_index,
    input  logic [lcbf_pkg::COLOR_W-1:0]  color,
    input  logic [lcbf_pkg::CHAN_W-1:0]   fade_amount,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lcbf_pkg::res_t                res,
    output logic                          mem_we,
    output logic [ADDR_W-1:0]             mem_waddr,
    output logic [lcbf_pkg::COLOR_W-1:0]  mem_wdata,
    output logic                          mem_re,
    output logic [ADDR_W-1:0]             mem_raddr,
    input  logic [lcbf_pkg::COLOR_W-1:0]  mem_rdata
);
    import lcbf_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LED_COUNT - 1);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CHAN_W-1:0]  amt_reg, amt_next;
    res_t               res_reg, res_next;
    logic               in_range;
    logic               at_last;

    assign in_range = {1'b0, led_index} < (IDX_W + 1)'(LED_COUNT);
    assign at_last  = (addr_reg == LAST_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg <= amt_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (at_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    case (op)
                        OP_FADE: state_next = ST_FADE;
                        OP_READ: state_next = in_range ? ST_READ : ST_RESULT;
                        default: state_next = ST_RESULT;
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_RESULT;
            end
            ST_FADE:
            begin
                if (at_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_ready   = 1'b0;
        res_valid = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = addr_reg + ADDR_W'(1);
        addr_next = addr_reg;
        amt_next  = amt_reg;
        res_next  = res_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = at_last ? '0 : addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    res_next = '0;
                    case (op)
                        OP_SET:
                        begin
                            if (in_range)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = led_index[ADDR_W-1:0];
                                mem_wdata = color;
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        OP_FADE:
                        begin
                            // Start the sweep: fetch entry zero now.
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            addr_next = '0;
                            amt_next  = fade_amount;
                        end
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = led_index[ADDR_W-1:0];
                            end
                            else
                            begin
                                res_next.status = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_next.color = mem_rdata;
            end
            ST_FADE:
            begin
                // Write back the entry fetched last cycle, fetch the next one.
                mem_we    = 1'b1;
                mem_wdata = fade_color(mem_rdata, amt_reg);
                mem_re    = !at_last;
                addr_next = at_last ? '0 : addr_reg + ADDR_W'(1);
            end
            ST_RESULT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res = res_reg;

endmodule

// ===== hw/rtl/led_color_buffer_with_fade.sv =====
// Top level of the LED color buffer with fade: stream ports and output register.
// Depends on lcbf_pkg, lcbf_mem and lcbf_ctrl.
//
//  port group   dir   payload
//  s_*          in    tuser: op; tdata: led_index, color, fade_amount
//  m_*          out   tuser: status; tdata: read_color
//
// A set, out-of-range or unused request goes from ST_IDLE to ST_RESULT, a read via ST_READ
// (one memory read), a fade via the ST_FADE sweep; ST_RESULT loads the result into the
// output register. The fade sweep does one memory entry per cycle through the one read port
// and the one write port. After reset a clearing pass writes black to all LED_COUNT entries,
// one per cycle, with s_tready low. Items are taken one at a time, the next one after the
// load; a result held while m_tready is low lets the next item run to its result.
module led_color_buffer_with_fade #(
    parameter int LED_COUNT = lcbf_pkg::LED_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lcbf_pkg::S_TDATA_W-1:0] s_tdata,  // led_index, color, fade_amount, zero pad
    input  logic [lcbf_pkg::OP_W-1:0]      s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lcbf_pkg::COLOR_W-1:0]   m_tdata,  // read_color
    output logic [0:0]                     m_tuser   // status
);
    import lcbf_pkg::*;

    localparam int ADDR_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [COLOR_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [COLOR_W-1:0] mem_rdata;

    logic               m_valid_reg, m_valid_next;
    res_t               m_res_reg;

    lcbf_ctrl #(
        .LED_COUNT (LED_COUNT),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .op          (s_tuser),
        .led_index   (s_tdata[IDX_W-1:0]),
        .color       (s_tdata[IDX_W +: COLOR_W]),
        .fade_amount (s_tdata[IDX_W + COLOR_W +: CHAN_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    lcbf_mem #(
        .LED_COUNT (LED_COUNT),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Load a new result when the output register is empty or being drained.
    assign res_ready    = !m_valid_reg || m_tready;
    assign m_valid_next = res_valid || (m_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.color;
    assign m_tuser  = m_res_reg.status;

endmodule

// ===== hw/rtl/lcbf_checker.sv =====
// Port-level checks for the LED color buffer with fade, bound to the top level.
// Depends on lcbf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcbf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lcbf_pkg::S_TDATA_W-1:0] s_tdata,  // led_index, color, fade_amount, zero pad
    input logic [lcbf_pkg::OP_W-1:0]      s_tuser,  // op
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lcbf_pkg::COLOR_W-1:0]   m_tdata,  // read_color
    input logic [0:0]                     m_tuser   // status
);
    import lcbf_pkg::*;

    // One item in flight: an input transfer closes the input side next cycle.
    `CHK_PROP(a_one_in_flight, ((s_tvalid && s_tready) |=> !s_tready), "input taken twice in a row")

    // A rejected index never carries a color.
    `CHK_NEVER(a_err_no_color, (m_tvalid && m_tuser[0] && (m_tdata != '0)), "color on error result")

    // Hold a stalled result.
    `CHK_PROP(a_out_hold, ((m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser))), "stalled result changed")

endmodule

bind led_color_buffer_with_fade lcbf_checker u_lcbf_checker (.*);
